>>> rtl/core/bounded_stable_priority_queue_macros.svh
// assertion macros for the bounded stable priority queue
// no dependencies; included by the top level only
`ifndef BOUNDED_STABLE_PRIORITY_QUEUE_MACROS_SVH
`define BOUNDED_STABLE_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
`define BSP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("bsp assertion failed");
`define BSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bsp assertion failed");
`define BSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bsp assertion failed");
`else
`define BSP_ASSERT(lbl, clk, rst_n, prop)
`define BSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/bsp_pkg.sv
// shared types and constants for the bounded stable priority queue
// no dependencies; used by every module of the block
package bsp_pkg;

	localparam int CMD_W = 2;
	localparam int VAL_W = 32;
	localparam int PRI_W = 16;
	localparam int CAP_W = 5;
	localparam int OCC_W = 5;
	localparam int STS_W = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

	localparam logic [STS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STATUS_FULL  = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [VAL_W-1:0] item_value;
		logic [PRI_W-1:0] item_priority;
	} request_t;

	typedef struct packed {
		logic [VAL_W-1:0] head_value;
		logic [STS_W-1:0] status;
		logic [OCC_W-1:0] occupancy;
		logic             is_empty;
		logic             is_full;
	} result_t;

	typedef struct packed {
		logic load;
		logic execute;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rsp_blocked;
	} ctrl_sts_t;

endpackage

>>> rtl/core/bsp_ctrl.sv
// controller for the bounded stable priority queue: capture and execute sequencing
// depends on bsp_pkg
module bsp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  bsp_pkg::ctrl_sts_t  sts,
	output bsp_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.load    = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!sts.rsp_blocked) begin
					cmd.execute = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/bsp_datapath.sv
// datapath for the bounded stable priority queue: sorted entry store, capacity
// register and result register; depends on bsp_pkg
module bsp_datapath #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [bsp_pkg::CAP_W-1:0]     cfg_data,
	input  bsp_pkg::request_t             req,
	input  bsp_pkg::ctrl_cmd_t            cmd,
	output bsp_pkg::ctrl_sts_t            sts,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output bsp_pkg::result_t              rsp
);

	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > bsp_pkg::CAP_W) ? CW : bsp_pkg::CAP_W;
	localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_ENTRIES);

	logic [bsp_pkg::VAL_W-1:0] val_q [MAX_ENTRIES];
	logic [bsp_pkg::PRI_W-1:0] pri_q [MAX_ENTRIES];
	logic [bsp_pkg::VAL_W-1:0] val_d [MAX_ENTRIES];
	logic [bsp_pkg::PRI_W-1:0] pri_d [MAX_ENTRIES];
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_d;
	logic [bsp_pkg::CAP_W-1:0] cap_q;
	bsp_pkg::request_t         item_q;
	bsp_pkg::result_t          rsp_q;
	logic                      rsp_valid_q;
	bsp_pkg::result_t          res;

	logic [MAX_ENTRIES-1:0] ge;
	logic [CMPW-1:0]        cap_ext;
	logic [CMPW-1:0]        cap_use;
	logic [CMPW-1:0]        cnt_ext;
	logic [CMPW-1:0]        next_ext;
	logic                   do_insert;
	logic                   do_remove;

	assign cap_ext = CMPW'(cap_q);
	assign cap_use = (cap_ext > MAX_C) ? MAX_C : cap_ext;
	assign cnt_ext = CMPW'(count_q);

	// slots ahead of the new entry: occupied and priority not below it
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cmp
		assign ge[i] = (CW'(i) < count_q) && (pri_q[i] >= item_q.item_priority);
	end

	always_comb begin
		res          = '0;
		res.status   = bsp_pkg::STATUS_OK;
		count_d      = count_q;
		do_insert    = 1'b0;
		do_remove    = 1'b0;
		unique case (item_q.command)
			bsp_pkg::CMD_INSERT: begin
				if (cnt_ext >= cap_use) begin
					res.status = bsp_pkg::STATUS_FULL;
				end else begin
					do_insert = 1'b1;
					count_d   = count_q + CW'(1);
				end
			end
			bsp_pkg::CMD_REMOVE, bsp_pkg::CMD_PEEK: begin
				if (count_q == '0) begin
					res.status = bsp_pkg::STATUS_EMPTY;
				end else begin
					res.head_value = val_q[0];
					if (item_q.command == bsp_pkg::CMD_REMOVE) begin
						do_remove = 1'b1;
						count_d   = count_q - CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
		next_ext      = CMPW'(count_d);
		res.occupancy = next_ext[bsp_pkg::OCC_W-1:0];
		res.is_empty  = (count_d == '0);
		res.is_full   = (next_ext >= cap_use);
	end

	// per-slot compare-and-shift
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_slot
		logic at_pos;
		if (i == 0) begin : g_head
			assign at_pos = !ge[0];
		end else begin : g_body
			assign at_pos = !ge[i] && ge[i-1];
		end

		always_comb begin
			val_d[i] = val_q[i];
			pri_d[i] = pri_q[i];
			if (do_insert && !ge[i]) begin
				if (at_pos) begin
					val_d[i] = item_q.item_value;
					pri_d[i] = item_q.item_priority;
				end else begin
					val_d[i] = val_q[(i > 0) ? i - 1 : 0];
					pri_d[i] = pri_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_remove && (i < MAX_ENTRIES - 1)) begin
				val_d[i] = val_q[(i < MAX_ENTRIES - 1) ? i + 1 : i];
				pri_d[i] = pri_q[(i < MAX_ENTRIES - 1) ? i + 1 : i];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.execute) begin
				val_q[i] <= val_d[i];
				pri_q[i] <= pri_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.execute) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= bsp_pkg::CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.execute) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.rsp_blocked = rsp_valid_q && !rsp_ready;
	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;

endmodule

>>> rtl/core/bounded_stable_priority_queue.sv
// top level of the bounded stable priority queue
// depends on bsp_pkg, bsp_ctrl, bsp_datapath and the assertion macro header
// Each accepted item's command is first captured into the item register and then run
// through the sorted compare-and-shift entry store, which writes every slot in
// parallel and loads the result register. A new item is taken in the cycle after
// its predecessor executes, so the block holds only one item at a time; a result
// left untaken in the result register holds the execute step until it is taken.
// Configuration writes are taken in any cycle.
`include "bounded_stable_priority_queue_macros.svh"

module bounded_stable_priority_queue #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bsp_pkg::CAP_W-1:0] cfg_data,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  bsp_pkg::request_t         req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output bsp_pkg::result_t          rsp
);

	bsp_pkg::ctrl_cmd_t ctl_cmd;
	bsp_pkg::ctrl_sts_t ctl_sts;

	assign cfg_ready = 1'b1;

	bsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (ctl_sts),
		.cmd       (ctl_cmd)
	);

	bsp_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (ctl_cmd),
		.sts       (ctl_sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`BSP_ASSERT_NEXT(a_one_item_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)
	`BSP_ASSERT_IMPL(a_exec_needs_free_slot, clk, arst_n, ctl_cmd.execute, !rsp_valid || rsp_ready)
	`BSP_ASSERT_IMPL(a_full_flag_on_full, clk, arst_n, rsp_valid && (rsp.status == bsp_pkg::STATUS_FULL), rsp.is_full)
	`BSP_ASSERT_IMPL(a_empty_error_shape, clk, arst_n, rsp_valid && (rsp.status == bsp_pkg::STATUS_EMPTY), rsp.is_empty && (rsp.head_value == '0))

endmodule

>>> tb/tb_bounded_stable_priority_queue.sv
// self-checking testbench for the bounded stable priority queue
// depends on bsp_pkg and the bounded_stable_priority_queue top level
// directed table first, then random command phases over several capacity settings
module tb_bounded_stable_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam logic [bsp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_PINNED,
		ROW_CAP
	} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		bsp_pkg::request_t          item;
		bsp_pkg::result_t           want;
		logic [bsp_pkg::CAP_W-1:0]  cap;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [bsp_pkg::CAP_W-1:0] cfg_data = '0;
	logic                      req_valid = 1'b0;
	logic                      req_ready;
	bsp_pkg::request_t         req = '0;
	logic                      rsp_valid;
	logic                      rsp_ready = 1'b0;
	bsp_pkg::result_t          rsp;

	// typed expectation travelling with the item on the request side
	logic                      pin_on = 1'b0;
	bsp_pkg::result_t          pin_want = '0;

	// predictor state
	logic [bsp_pkg::VAL_W-1:0] held_value [DEPTH];
	logic [bsp_pkg::PRI_W-1:0] held_priority [DEPTH];
	int unsigned               held_count = 0;
	logic [bsp_pkg::CAP_W-1:0] cap_reg = bsp_pkg::CAP_RESET;

	bsp_pkg::result_t          pending_results [$];
	dir_row_t                  dir_rows [$];

	int sent_count = 0;
	int checked_count = 0;
	int fail_count = 0;
	int full_count = 0;
	int empty_count = 0;
	int cap_writes = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;

	bounded_stable_priority_queue #(
		.MAX_ENTRIES(DEPTH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bsp_pkg::result_t serve_command(bsp_pkg::request_t r);
		bsp_pkg::result_t o;
		int unsigned      cap;
		int unsigned      pos;
		int unsigned      i;
		cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
		o = '0;
		o.status = bsp_pkg::STATUS_OK;
		unique case (r.command)
			bsp_pkg::CMD_INSERT: begin
				if (held_count >= cap) begin
					o.status = bsp_pkg::STATUS_FULL;
				end else begin
					pos = 0;
					while (pos < held_count && held_priority[pos] >= r.item_priority)
						pos++;
					for (i = held_count; i > pos; i--) begin
						held_value[i] = held_value[i-1];
						held_priority[i] = held_priority[i-1];
					end
					held_value[pos] = r.item_value;
					held_priority[pos] = r.item_priority;
					held_count++;
				end
			end
			bsp_pkg::CMD_REMOVE, bsp_pkg::CMD_PEEK: begin
				if (held_count == 0) begin
					o.status = bsp_pkg::STATUS_EMPTY;
				end else begin
					o.head_value = held_value[0];
					if (r.command == bsp_pkg::CMD_REMOVE) begin
						for (i = 0; i + 1 < held_count; i++) begin
							held_value[i] = held_value[i+1];
							held_priority[i] = held_priority[i+1];
						end
						held_count--;
					end
				end
			end
			default: ;
		endcase
		o.occupancy = held_count[bsp_pkg::OCC_W-1:0];
		o.is_empty = (held_count == 0);
		o.is_full = (held_count >= cap);
		return o;
	endfunction

	// request and result monitor
	always @(posedge clk) begin
		bsp_pkg::result_t want;
		bsp_pkg::result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				cap_reg = cfg_data;
			if (req_valid && req_ready) begin
				want = serve_command(req);
				if (pin_on)
					want = pin_want;
				if (want.status == bsp_pkg::STATUS_FULL)
					full_count++;
				if (want.status == bsp_pkg::STATUS_EMPTY)
					empty_count++;
				pending_results.push_back(want);
			end
			if (rsp_valid && rsp_ready) begin
				got = rsp;
				if (pending_results.size() == 0) begin
					$error("result with no item outstanding: %h", got);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.head_value !== want.head_value) begin
						$error("head_value: expected %0h, actual %0h",
							want.head_value, got.head_value);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, actual %0d",
							want.occupancy, got.occupancy);
						fail_count++;
					end
					if (got.is_empty !== want.is_empty) begin
						$error("is_empty: expected %0b, actual %0b",
							want.is_empty, got.is_empty);
						fail_count++;
					end
					if (got.is_full !== want.is_full) begin
						$error("is_full: expected %0b, actual %0b", want.is_full, got.is_full);
						fail_count++;
					end
				end
				checked_count++;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
			stall_left = $urandom_range(1, 10);
		rsp_ready <= (stall_left == 0);
	end

	function automatic bsp_pkg::result_t res(logic [bsp_pkg::VAL_W-1:0] head,
		logic [bsp_pkg::STS_W-1:0] sts, logic [bsp_pkg::OCC_W-1:0] occ, logic empty,
		logic full);
		bsp_pkg::result_t o;
		o.head_value = head;
		o.status = sts;
		o.occupancy = occ;
		o.is_empty = empty;
		o.is_full = full;
		return o;
	endfunction

	function automatic dir_row_t item_row(logic [bsp_pkg::CMD_W-1:0] cmd,
		logic [bsp_pkg::VAL_W-1:0] v, logic [bsp_pkg::PRI_W-1:0] p);
		dir_row_t row;
		row.kind = ROW_ITEM;
		row.item.command = cmd;
		row.item.item_value = v;
		row.item.item_priority = p;
		row.want = '0;
		row.cap = '0;
		return row;
	endfunction

	function automatic dir_row_t pinned_row(logic [bsp_pkg::CMD_W-1:0] cmd,
		logic [bsp_pkg::VAL_W-1:0] v, logic [bsp_pkg::PRI_W-1:0] p,
		bsp_pkg::result_t want);
		dir_row_t row;
		row = item_row(cmd, v, p);
		row.kind = ROW_PINNED;
		row.want = want;
		return row;
	endfunction

	function automatic dir_row_t cap_row(logic [bsp_pkg::CAP_W-1:0] cap);
		dir_row_t row;
		row = item_row(bsp_pkg::CMD_INSERT, '0, '0);
		row.kind = ROW_CAP;
		row.cap = cap;
		return row;
	endfunction

	task automatic send_item(bsp_pkg::request_t item, logic pinned, bsp_pkg::result_t want);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		pin_on <= pinned;
		pin_want <= want;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent_count++;
	endtask

	task automatic wait_idle();
		if (req_valid)
			req_valid <= 1'b0;
		while (checked_count != sent_count) @(posedge clk);
	endtask

	task automatic write_cap(logic [bsp_pkg::CAP_W-1:0] cap);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_writes++;
		@(posedge clk);
	endtask

	function automatic bsp_pkg::request_t random_item(int ins_pct);
		bsp_pkg::request_t r;
		int                roll;
		logic [31:0]       rnd;
		roll = $urandom_range(99);
		if (roll < ins_pct)
			r.command = bsp_pkg::CMD_INSERT;
		else if (roll < 97)
			r.command = ($urandom_range(2) == 0) ? bsp_pkg::CMD_PEEK : bsp_pkg::CMD_REMOVE;
		else
			r.command = CMD_UNUSED;
		roll = $urandom_range(99);
		if (roll < 50) begin
			rnd = $urandom_range(3);
			r.item_priority = rnd[bsp_pkg::PRI_W-1:0];
		end else if (roll < 60) begin
			r.item_priority = ($urandom_range(1) == 0) ? '0 : '1;
		end else begin
			rnd = $urandom;
			r.item_priority = rnd[bsp_pkg::PRI_W-1:0];
		end
		roll = $urandom_range(99);
		if (roll < 5)
			r.item_value = '0;
		else if (roll < 10)
			r.item_value = '1;
		else
			r.item_value = $urandom;
		return r;
	endfunction

	task automatic run_phase(logic [bsp_pkg::CAP_W-1:0] cap, int ins_pct, int count, int gap,
		int stall);
		write_cap(cap);
		gap_pct = gap;
		stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			// wait for every outstanding result now and then before the next item
			if (n == count / 2 || (n > 0 && $urandom_range(199) == 0))
				wait_idle();
			send_item(random_item(ins_pct), 1'b0, '0);
		end
	endtask

	initial begin
		dir_row_t row;
		int       pick;

		dir_rows.push_back(pinned_row(bsp_pkg::CMD_PEEK, '0, '0,
			res('0, bsp_pkg::STATUS_EMPTY, 5'd0, 1'b1, 1'b0)));
		dir_rows.push_back(pinned_row(bsp_pkg::CMD_REMOVE, '1, '1,
			res('0, bsp_pkg::STATUS_EMPTY, 5'd0, 1'b1, 1'b0)));
		dir_rows.push_back(pinned_row(CMD_UNUSED, '1, '1,
			res('0, bsp_pkg::STATUS_OK, 5'd0, 1'b1, 1'b0)));
		dir_rows.push_back(pinned_row(bsp_pkg::CMD_INSERT, '1, '0,
			res('0, bsp_pkg::STATUS_OK, 5'd1, 1'b0, 1'b0)));
		dir_rows.push_back(pinned_row(bsp_pkg::CMD_INSERT, '0, '1,
			res('0, bsp_pkg::STATUS_OK, 5'd2, 1'b0, 1'b0)));
		dir_rows.push_back(item_row(bsp_pkg::CMD_INSERT, 32'hA5A5_5A5A, 16'hFFFF));
		dir_rows.push_back(item_row(bsp_pkg::CMD_INSERT, 32'h0000_1234, 16'h0000));
		dir_rows.push_back(item_row(bsp_pkg::CMD_PEEK, '0, '0));
		dir_rows.push_back(item_row(bsp_pkg::CMD_REMOVE, '0, '0));
		dir_rows.push_back(item_row(bsp_pkg::CMD_REMOVE, '0, '0));
		dir_rows.push_back(item_row(bsp_pkg::CMD_INSERT, 32'h5EED_F00D, 16'h8000));
		dir_rows.push_back(item_row(bsp_pkg::CMD_PEEK, '0, '0));
		dir_rows.push_back(item_row(bsp_pkg::CMD_REMOVE, '0, '0));
		dir_rows.push_back(item_row(bsp_pkg::CMD_REMOVE, '0, '0));
		dir_rows.push_back(item_row(bsp_pkg::CMD_REMOVE, '0, '0));
		dir_rows.push_back(pinned_row(bsp_pkg::CMD_REMOVE, '0, '0,
			res('0, bsp_pkg::STATUS_EMPTY, 5'd0, 1'b1, 1'b0)));
		// zero capacity: full and empty at once
		dir_rows.push_back(cap_row(5'd0));
		dir_rows.push_back(pinned_row(bsp_pkg::CMD_INSERT, '0, '0,
			res('0, bsp_pkg::STATUS_FULL, 5'd0, 1'b1, 1'b1)));
		dir_rows.push_back(pinned_row(bsp_pkg::CMD_PEEK, '0, '0,
			res('0, bsp_pkg::STATUS_EMPTY, 5'd0, 1'b1, 1'b1)));
		dir_rows.push_back(cap_row(5'd2));
		dir_rows.push_back(pinned_row(bsp_pkg::CMD_INSERT, 32'd1, 16'd7,
			res('0, bsp_pkg::STATUS_OK, 5'd1, 1'b0, 1'b0)));
		dir_rows.push_back(pinned_row(bsp_pkg::CMD_INSERT, 32'd2, 16'd7,
			res('0, bsp_pkg::STATUS_OK, 5'd2, 1'b0, 1'b1)));
		dir_rows.push_back(pinned_row(bsp_pkg::CMD_INSERT, 32'd3, '1,
			res('0, bsp_pkg::STATUS_FULL, 5'd2, 1'b0, 1'b1)));
		// capacity below occupancy
		dir_rows.push_back(cap_row(5'd1));
		dir_rows.push_back(pinned_row(bsp_pkg::CMD_INSERT, 32'd4, '0,
			res('0, bsp_pkg::STATUS_FULL, 5'd2, 1'b0, 1'b1)));
		dir_rows.push_back(item_row(bsp_pkg::CMD_REMOVE, '0, '0));
		dir_rows.push_back(item_row(bsp_pkg::CMD_REMOVE, '0, '0));
		// register above store depth
		dir_rows.push_back(cap_row(5'd31));
		dir_rows.push_back(item_row(CMD_UNUSED, 32'hDEAD_BEEF, 16'h1234));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 20;
		stall_pct = 20;
		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			if (row.kind == ROW_CAP)
				write_cap(row.cap);
			else
				send_item(row.item, row.kind == ROW_PINNED, row.want);
		end

		run_phase(5'd16, 65, 200, 25, 25);
		run_phase(5'd31, 55, 200, 20, 20);
		run_phase(5'd3, 50, 150, 30, 30);
		run_phase(5'd0, 50, 60, 20, 20);
		run_phase(5'd16, 80, 100, 10, 10);
		run_phase(5'd4, 45, 200, 20, 20);
		pick = $urandom_range(1, 15);
		run_phase(pick[bsp_pkg::CAP_W-1:0], 50, 200, 20, 0);
		run_phase(5'd1, 50, 100, 0, 30);
		run_phase(5'd16, 55, 290, 0, 0);

		wait_idle();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			fail_count++;
		end
		$display("%0d items sent, %0d results checked over %0d capacity writes",
			sent_count, checked_count, cap_writes);
		$display("%0d inserts refused as full, %0d reads of an empty queue",
			full_count, empty_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
